[rtl/bgcd_pkg.sv]
// Shared types and constants for the binary GCD block.
// No dependencies; used by every other file of the block.
package bgcd_pkg;

	localparam int WIDTH   = 32;
	localparam int STEPS   = 2 * WIDTH;
	localparam int CNT_W   = $clog2(STEPS + 1);

	typedef logic [WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic load;      // take a new pair of operands
		logic step;      // one Stein iteration
		logic load_out;  // capture the shifted result
	} cmd_t;

	typedef struct packed {
		logic finish;    // operands equal, one zero, or step bound reached
	} status_t;

endpackage

[rtl/bgcd_in_if.sv]
// Request channel carrying the two operands.
// Depends on bgcd_pkg.
interface bgcd_in_if;
	logic               valid;
	logic               ready;
	bgcd_pkg::word_t    first_operand;
	bgcd_pkg::word_t    second_operand;

	modport source (output valid, output first_operand, output second_operand, input ready);
	modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

[rtl/bgcd_out_if.sv]
// Result channel carrying the divisor.
// Depends on bgcd_pkg.
interface bgcd_out_if;
	logic               valid;
	logic               ready;
	bgcd_pkg::word_t    divisor;

	modport source (output valid, output divisor, input ready);
	modport sink   (input valid, input divisor, output ready);
endinterface

[rtl/bgcd_dp.sv]
// Datapath: operand registers, shared-twos count, step counter, result register.
// Depends on bgcd_pkg; driven by bgcd_ctrl through cmd_t / status_t.
module bgcd_dp (
	input  logic                clk,
	input  bgcd_pkg::cmd_t      cmd,
	input  bgcd_pkg::word_t     first_operand,
	input  bgcd_pkg::word_t     second_operand,
	output bgcd_pkg::status_t   status,
	output bgcd_pkg::word_t     divisor
);

	bgcd_pkg::word_t a_q, b_q, res_q, diff, base;
	bgcd_pkg::cnt_t  sh_q, it_q;
	logic            a_gt_b;

	assign a_gt_b = a_q > b_q;
	assign diff   = a_gt_b ? (a_q - b_q) : (b_q - a_q);
	assign base   = (a_q == '0) ? b_q : a_q;

	assign status.finish = (a_q == b_q) || (a_q == '0) || (b_q == '0) ||
		(it_q == bgcd_pkg::CNT_W'(bgcd_pkg::STEPS));
	assign divisor = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q  <= first_operand;
			b_q  <= second_operand;
			sh_q <= '0;
			it_q <= '0;
		end else if (cmd.step) begin
			it_q <= it_q + 1'b1;
			if (!a_q[0]) begin
				if (!b_q[0]) begin
					b_q  <= b_q >> 1;
					sh_q <= sh_q + 1'b1;
				end
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_gt_b) begin
				a_q <= diff >> 1;
			end else begin
				b_q <= diff >> 1;
			end
		end
		if (cmd.load_out) begin
			res_q <= base << sh_q;
		end
	end

endmodule

[rtl/bgcd_ctrl.sv]
// Controller: sequences load, iteration and result hand-off.
// Depends on bgcd_pkg; commands bgcd_dp.
module bgcd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  bgcd_pkg::status_t   status,
	output bgcd_pkg::cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q, state_d;
	logic       out_valid_q, out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.step     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!status.finish) begin
					cmd.step = 1'b1;
				end else if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/binary_gcd.sv]
// Binary GCD (Stein) top level: controller plus datapath.
// Depends on bgcd_pkg, bgcd_in_if, bgcd_out_if, bgcd_ctrl, bgcd_dp.
//
// operands: request channel with first_operand and second_operand, valid/ready.
// result:   result channel with divisor, valid/ready; one result per request.
// A request is taken only when the previous one has left the iteration loop.
// Sequence: a load, then the Stein iterations (at most 2*WIDTH,
// 64 for 32-bit operands), then a shift of the shared factors
// of two back into the output register. The iteration count depends on the
// operands; only one request is in the iteration loop at a time.
// The output register frees the iteration loop: a finished result waits
// there while the next request is loaded and iterated.
// If the receiver stalls with a result still held and another one finished,
// the block waits with operands ready held low until the register frees.
// gcd(0,0) is 0 and gcd(x,0) is x.
// Reset (arst_n low) clears the output valid flag and returns to idle;
// no memory, no clearing pass.
module binary_gcd (
	input  logic       clk,
	input  logic       arst_n,
	bgcd_in_if.sink    operands,
	bgcd_out_if.source result
);

	bgcd_pkg::cmd_t    cmd;
	bgcd_pkg::status_t status;

	bgcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bgcd_dp u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.first_operand  (operands.first_operand),
		.second_operand (operands.second_operand),
		.status         (status),
		.divisor        (result.divisor)
	);

endmodule

[tb/bgcd_checker.sv]
// Checker for the binary GCD block: watches both channels and predicts each divisor.
// Depends on bgcd_pkg; instantiated by tb beside the block.
module bgcd_checker
	import bgcd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_ready,
	input  word_t first_operand,
	input  word_t second_operand,
	input  logic  out_valid,
	input  logic  out_ready,
	input  word_t divisor,
	output int    fails,
	output int    checked,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	word_t gcd_due[$];

	// Stein iteration, bounded as in the block
	function automatic word_t expected_gcd(word_t x, word_t y);
		word_t a;
		word_t b;
		int    shared;
		a = x;
		b = y;
		shared = 0;
		for (int i = 0; i < STEPS; i++) begin
			if (a == b || a == 0 || b == 0)
				break;
			if (!a[0]) begin
				if (!b[0]) begin
					b = b >> 1;
					shared++;
				end
				a = a >> 1;
			end else if (!b[0]) begin
				b = b >> 1;
			end else if (a > b) begin
				a = (a - b) >> 1;
			end else begin
				b = (b - a) >> 1;
			end
		end
		return ((a == 0) ? b : a) << shared;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			gcd_due.delete();
			fails   <= 0;
			checked <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				gcd_due.push_back(expected_gcd(first_operand, second_operand));
			if (out_valid && out_ready) begin
				if (gcd_due.size() == 0) begin
					if (fails < 10)
						$display("%t: divisor %h with no request outstanding", $realtime, divisor);
					fails <= fails + 1;
				end else begin
					want = gcd_due.pop_front();
					if (divisor !== want) begin
						if (fails < 10)
							$display("%t: divisor expected %h got %h", $realtime, want, divisor);
						fails <= fails + 1;
					end
					checked <= checked + 1;
				end
			end
			pending <= gcd_due.size();
		end
	end

endmodule

[tb/tb.sv]
// Top of the binary GCD testbench: clock, reset, request and result traffic, verdict.
// Depends on bgcd_pkg, bgcd_in_if, bgcd_out_if, binary_gcd and bgcd_checker.
module tb;
	import bgcd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 1600;
	localparam int LIMIT      = 1000000;
	localparam int HOLD_AT    = 3000;
	localparam int HOLD_LEN   = 400;
	localparam int CALM_LO    = 20000;
	localparam int CALM_HI    = 40000;
	localparam word_t ALL_ONES = '1;

	logic clk;
	logic arst_n;
	int   cycles;
	int   sent;
	int   fails;
	int   checked;
	int   pending;
	bit   calm_send;

	bgcd_in_if  operands_if();
	bgcd_out_if result_if();

	binary_gcd DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_if),
		.result   (result_if)
	);

	bgcd_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (operands_if.valid),
		.in_ready       (operands_if.ready),
		.first_operand  (operands_if.first_operand),
		.second_operand (operands_if.second_operand),
		.out_valid      (result_if.valid),
		.out_ready      (result_if.ready),
		.divisor        (result_if.divisor),
		.fails          (fails),
		.checked        (checked),
		.pending        (pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// receiver: random stalls, one long hold so the block backs up, then a calm stretch
	initial begin
		int n;
		n = 0;
		result_if.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n++;
			if (n >= HOLD_AT && n < HOLD_AT + HOLD_LEN)
				result_if.ready = 0;
			else if (n >= CALM_LO && n < CALM_HI)
				result_if.ready = 1;
			else
				result_if.ready = ($urandom_range(99) >= 22);
		end
	end

	// called at a falling edge, returns at a falling edge once the request is taken
	task automatic send_pair(word_t a, word_t b);
		while (!calm_send && $urandom_range(99) < 22) begin
			operands_if.valid = 0;
			@(negedge clk);
		end
		operands_if.valid          = 1;
		operands_if.first_operand  = a;
		operands_if.second_operand = b;
		@(posedge clk);
		while (!operands_if.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic random_pair(output word_t a, output word_t b);
		word_t  g;
		int     k;
		longint f0;
		longint f1;
		longint t;
		k = $urandom_range(WIDTH - 1);
		case ($urandom_range(9))
			3: begin
				g = $urandom_range(65535, 1);
				a = g * $urandom_range(65535);
				b = g * $urandom_range(65535);
				a = a << $urandom_range(8);
				b = b << $urandom_range(8);
			end
			4: begin
				a = $urandom << k;
				b = $urandom << $urandom_range(WIDTH - 1);
			end
			5: begin
				a = $urandom;
				b = 0;
				if ($urandom_range(1)) begin
					b = a;
					a = 0;
				end
			end
			6: begin
				a = $urandom >> $urandom_range(WIDTH - 1);
				b = a;
			end
			7: begin
				a = $urandom_range(255);
				b = $urandom_range(255);
			end
			8: begin
				a = ALL_ONES - $urandom_range(1023);
				b = ALL_ONES - $urandom_range(1023);
			end
			9: begin
				// consecutive Fibonacci terms
				f0 = 0;
				f1 = 1;
				repeat ($urandom_range(46, 2)) begin
					t  = f0 + f1;
					f0 = f1;
					f1 = t;
				end
				a = word_t'(f0);
				b = word_t'(f1);
				if ($urandom_range(1)) begin
					a = word_t'(f1);
					b = word_t'(f0);
				end
			end
			default: begin
				a = $urandom;
				b = $urandom;
			end
		endcase
	endtask

	initial begin
		word_t a;
		word_t b;
		cycles    = 0;
		sent      = 0;
		calm_send = 0;
		arst_n    = 0;
		operands_if.valid          = 0;
		operands_if.first_operand  = '0;
		operands_if.second_operand = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_pair(0, 0);
		send_pair(ALL_ONES, 0);
		send_pair(0, ALL_ONES);
		send_pair(0, 1);
		send_pair(12345, 12345);
		send_pair(ALL_ONES, ALL_ONES);
		send_pair(ALL_ONES, 1);
		send_pair(1, ALL_ONES);
		send_pair(32'h8000_0000, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'h4000_0000);
		send_pair(32'h8000_0000, 1);
		send_pair(1, 32'h8000_0000);
		send_pair(48, 18);
		send_pair(18, 48);
		send_pair(32'd2971215073, 32'd1836311903);
		send_pair(32'hFFFF_FFFE, ALL_ONES);
		send_pair(32'hAAAA_AAAA, 32'h5555_5555);
		send_pair(32'hAAAA_AAAA, 32'h5555_5554);
		send_pair(ALL_ONES, 32'h7FFF_FFFF);
		send_pair(32'hC000_0000, 32'h0000_0006);
		send_pair(1, 1);
		send_pair(97, 89);

		for (int i = 0; i < N_RANDOM; i++) begin
			calm_send = (i >= 500 && i < 900);
			random_pair(a, b);
			send_pair(a, b);
		end
		calm_send = 0;
		operands_if.valid = 0;

		while (pending != 0 || result_if.valid)
			@(posedge clk);
		repeat (2 * STEPS + 8) @(posedge clk);

		$display("tb: %0d requests, %0d divisors checked in %0d cycles", sent, checked, cycles);
		$display("tb: zero, equal, power-of-two, common-factor and Fibonacci operands, %0d-cycle hold",
			HOLD_LEN);
		if (fails == 0 && pending == 0 && checked == sent)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
